[rtl/core/bvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvt_pkg
// Shared widths, action and status codes, and the command that drives the
// row of list cells.
// ----------------------------------------------------------------------------
package bvt_pkg;

   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 5;
   localparam int WORD_W     = 32;
   localparam int INDEX_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 3;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd6;

   // result status
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

   // what every cell does in one cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_WRITE  = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DELETE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [WORD_W-1:0]        value;
   } cell_cmd_type;

endpackage

[rtl/core/bvt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvt_if
// Valid/ready channels for list requests and list results.
// ----------------------------------------------------------------------------
interface bvt_req_if;
   logic                                valid;
   logic                                ready;
   logic [bvt_pkg::ACTION_W-1:0]        action;
   logic [bvt_pkg::POSITION_W-1:0]      position;
   logic signed [bvt_pkg::WORD_W-1:0]   value;

   modport source (output valid, output action, output position, output value,
                   input ready);
   modport sink   (input valid, input action, input position, input value,
                   output ready);
endinterface

interface bvt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bvt_pkg::WORD_W-1:0]   data_out;
   logic [bvt_pkg::INDEX_W-1:0]         found_index;
   logic [bvt_pkg::COUNT_W-1:0]         removed_count;
   logic [bvt_pkg::COUNT_W-1:0]         element_count;
   logic                                empty_flag;
   logic [bvt_pkg::STATUS_W-1:0]        status;

   modport source (output valid, output data_out, output found_index,
                   output removed_count, output element_count, output empty_flag,
                   output status, input ready);
   modport sink   (input valid, input data_out, input found_index,
                   input removed_count, input element_count, input empty_flag,
                   input status, output ready);
endinterface

[rtl/core/bvt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvt_cell
// One list slot: holds a word, takes it from the left or right neighbor on a
// shift, compares it with the search key and drives it on a read tap.
// ----------------------------------------------------------------------------
module bvt_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                          clock,
   input  bvt_pkg::cell_cmd_type         cmd,
   input  logic [CW-1:0]                 cmd_pos,
   input  logic [CW-1:0]                 cmd_cnt,
   input  logic [bvt_pkg::WORD_W-1:0]    key,
   input  logic [CW-1:0]                 rd_sel,
   input  logic [bvt_pkg::WORD_W-1:0]    left_word,
   input  logic [bvt_pkg::WORD_W-1:0]    right_word,
   output logic [bvt_pkg::WORD_W-1:0]    word,
   output logic                          match,
   output logic [bvt_pkg::WORD_W-1:0]    tap
);

   localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

   logic [bvt_pkg::WORD_W-1:0] word_ff;
   logic [bvt_pkg::WORD_W-1:0] word_in;
   logic                       below_last;

   // slot sits below the last occupied slot
   assign below_last = ({1'b0, MY_IDX} + (CW+1)'(1)) < {1'b0, cmd_cnt};

   // next word from the shared command
   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         bvt_pkg::CELL_WRITE: begin
            if (MY_IDX == cmd_pos) word_in = cmd.value;
         end
         bvt_pkg::CELL_INSERT: begin
            if (MY_IDX == cmd_pos) begin
               word_in = cmd.value;
            end else if (MY_IDX > cmd_pos && MY_IDX <= cmd_cnt) begin
               word_in = left_word;
            end
         end
         bvt_pkg::CELL_DELETE: begin
            if (MY_IDX >= cmd_pos && below_last) word_in = right_word;
         end
         default: word_in = word_ff;
      endcase
   end

   // slot storage
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = (word_ff == key);
   assign tap   = (MY_IDX == rd_sel) ? word_ff : '0;

endmodule

[rtl/core/bounded_vector_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vector_table
// Fixed-capacity ordered list of 32-bit words built as a row of cells that
// shift in parallel; value removal and search walk the row one slot a cycle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req_bus   in   valid / ready        action, position, value
//  rsp_bus   out  valid / ready        data_out, found_index, removed_count,
//                                      element_count, empty_flag, status
//
// append, pop, insert, delete, read, unknown and failed requests go from the
// transfer straight to the completion stage, which loads the result register.
// remove value and find value walk the slots from the front; each walk step
// drops the slot under the cursor or advances it until a find hit or the end.
// reset clears the count, the control state and the result valid; slot words
// hold no reset value and are only read below the count.
// one finished item waits in the completion stage while the result register
// is stalled; the next request is taken once it moves on.
// ----------------------------------------------------------------------------
module bounded_vector_table #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   bvt_req_if.sink     req_bus,
   bvt_rsp_if.source   rsp_bus
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int PW = bvt_pkg::POSITION_W;
   localparam int XW = (CW > PW) ? CW : PW;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [CW-1:0]                    scan_ff, scan_in;
   logic                             scan_rm_ff, scan_rm_in;
   logic [bvt_pkg::WORD_W-1:0]       key_ff, key_in;
   logic [bvt_pkg::WORD_W-1:0]       res_data_ff, res_data_in;
   logic [IW-1:0]                    res_idx_ff, res_idx_in;
   logic [CW-1:0]                    res_rem_ff, res_rem_in;
   logic [bvt_pkg::STATUS_W-1:0]     res_stat_ff, res_stat_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bvt_pkg::WORD_W-1:0]       rsp_data_ff;
   logic [bvt_pkg::INDEX_W-1:0]      rsp_idx_ff;
   logic [bvt_pkg::COUNT_W-1:0]      rsp_rem_ff;
   logic [bvt_pkg::COUNT_W-1:0]      rsp_cnt_ff;
   logic                             rsp_empty_ff;
   logic [bvt_pkg::STATUS_W-1:0]     rsp_stat_ff;

   bvt_pkg::cell_cmd_type            cell_cmd;
   logic [CW-1:0]                    cmd_pos;
   logic [CW-1:0]                    rd_sel;
   logic [bvt_pkg::WORD_W-1:0]       word_w [CAPACITY];
   logic [bvt_pkg::WORD_W-1:0]       tap_w  [CAPACITY];
   logic [CAPACITY-1:0]              eq_vec;
   logic [bvt_pkg::WORD_W-1:0]       rd_data;

   logic                             req_xfer;
   logic                             rsp_load;
   logic                             scan_live;
   logic                             scan_hit;
   logic [XW-1:0]                    pos_x;
   logic [XW-1:0]                    cnt_x;
   logic [CW-1:0]                    pos_cw;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign pos_x  = XW'(req_bus.position);
   assign cnt_x  = XW'(cnt_ff);
   assign pos_cw = CW'(req_bus.position);

   assign scan_live = (scan_ff < cnt_ff);
   assign scan_hit  = scan_live && eq_vec[scan_ff[IW-1:0]];

   // row of list cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [bvt_pkg::WORD_W-1:0] left_w;
      logic [bvt_pkg::WORD_W-1:0] right_w;

      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = word_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = word_w[g+1];
      end

      bvt_cell #(
         .INDEX (g),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cmd_pos    (cmd_pos),
         .cmd_cnt    (cnt_ff),
         .key        (key_ff),
         .rd_sel     (rd_sel),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (word_w[g]),
         .match      (eq_vec[g]),
         .tap        (tap_w[g])
      );
   end

   // read tap collection
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | tap_w[i];
      end
   end

   // read slot select
   assign rd_sel = (req_bus.action == bvt_pkg::ACT_POP) ? (cnt_ff - CW'(1)) : pos_cw;

   // request decode and slot walk
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      scan_in     = scan_ff;
      scan_rm_in  = scan_rm_ff;
      key_in      = key_ff;
      res_data_in = res_data_ff;
      res_idx_in  = res_idx_ff;
      res_rem_in  = res_rem_ff;
      res_stat_in = res_stat_ff;
      cell_cmd.op    = bvt_pkg::CELL_HOLD;
      cell_cmd.value = req_bus.value;
      cmd_pos        = pos_cw;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_data_in = '0;
               res_idx_in  = '0;
               res_rem_in  = '0;
               res_stat_in = bvt_pkg::STAT_OK;
               state_in    = ST_DONE;
               case (req_bus.action)
                  bvt_pkg::ACT_APPEND: begin
                     if (cnt_ff >= CAP_C) begin
                        res_stat_in = bvt_pkg::STAT_FULL;
                     end else begin
                        cell_cmd.op = bvt_pkg::CELL_WRITE;
                        cmd_pos     = cnt_ff;
                        cnt_in      = cnt_ff + CW'(1);
                     end
                  end
                  bvt_pkg::ACT_POP: begin
                     if (cnt_ff == '0) begin
                        res_stat_in = bvt_pkg::STAT_EMPTY;
                     end else begin
                        res_data_in = rd_data;
                        cnt_in      = cnt_ff - CW'(1);
                     end
                  end
                  bvt_pkg::ACT_INSERT: begin
                     if (pos_x > cnt_x) begin
                        res_stat_in = bvt_pkg::STAT_BADPOS;
                     end else if (cnt_ff >= CAP_C) begin
                        res_stat_in = bvt_pkg::STAT_FULL;
                     end else begin
                        cell_cmd.op = bvt_pkg::CELL_INSERT;
                        cnt_in      = cnt_ff + CW'(1);
                     end
                  end
                  bvt_pkg::ACT_DELETE: begin
                     if (cnt_ff == '0) begin
                        res_stat_in = bvt_pkg::STAT_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        res_stat_in = bvt_pkg::STAT_BADPOS;
                     end else begin
                        cell_cmd.op = bvt_pkg::CELL_DELETE;
                        cnt_in      = cnt_ff - CW'(1);
                     end
                  end
                  bvt_pkg::ACT_REMOVE, bvt_pkg::ACT_FIND: begin
                     if (cnt_ff == '0) begin
                        res_stat_in = bvt_pkg::STAT_EMPTY;
                     end else begin
                        scan_in    = '0;
                        scan_rm_in = (req_bus.action == bvt_pkg::ACT_REMOVE);
                        key_in     = req_bus.value;
                        state_in   = ST_SCAN;
                     end
                  end
                  bvt_pkg::ACT_READ: begin
                     if (cnt_ff == '0) begin
                        res_stat_in = bvt_pkg::STAT_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        res_stat_in = bvt_pkg::STAT_BADPOS;
                     end else begin
                        res_data_in = rd_data;
                     end
                  end
                  default: res_stat_in = bvt_pkg::STAT_OK;
               endcase
            end
         end
         ST_SCAN: begin
            cmd_pos = scan_ff;
            if (!scan_live) begin
               // walked past the last slot
               state_in = ST_DONE;
               if (scan_rm_ff && res_rem_ff != '0) begin
                  res_stat_in = bvt_pkg::STAT_OK;
               end else begin
                  res_stat_in = bvt_pkg::STAT_NOTFOUND;
               end
            end else if (scan_hit) begin
               if (scan_rm_ff) begin
                  // drop the slot under the cursor, cursor stays
                  cell_cmd.op = bvt_pkg::CELL_DELETE;
                  cnt_in      = cnt_ff - CW'(1);
                  res_rem_in  = res_rem_ff + CW'(1);
               end else begin
                  res_idx_in  = IW'(scan_ff);
                  res_stat_in = bvt_pkg::STAT_OK;
                  state_in    = ST_DONE;
               end
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and completion payload
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      scan_rm_ff  <= scan_rm_in;
      key_ff      <= key_in;
      res_data_ff <= res_data_in;
      res_idx_ff  <= res_idx_in;
      res_rem_ff  <= res_rem_in;
      res_stat_ff <= res_stat_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff  <= res_data_ff;
         rsp_idx_ff   <= bvt_pkg::INDEX_W'(res_idx_ff);
         rsp_rem_ff   <= bvt_pkg::COUNT_W'(res_rem_ff);
         rsp_cnt_ff   <= bvt_pkg::COUNT_W'(cnt_ff);
         rsp_empty_ff <= (cnt_ff == '0);
         rsp_stat_ff  <= res_stat_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.data_out      = rsp_data_ff;
   assign rsp_bus.found_index   = rsp_idx_ff;
   assign rsp_bus.removed_count = rsp_rem_ff;
   assign rsp_bus.element_count = rsp_cnt_ff;
   assign rsp_bus.empty_flag    = rsp_empty_ff;
   assign rsp_bus.status        = rsp_stat_ff;

   // count never exceeds capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_C)
      else $error("element count above capacity");

   // walk cursor never moves past the count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= cnt_ff))
      else $error("walk cursor past count");

   // a dropped slot shortens the list by one
   a_remove_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_rm_ff && scan_hit)
      |=> (cnt_ff == $past(cnt_ff) - CW'(1)) && (state_ff == ST_SCAN))
      else $error("remove step did not shorten the list");

   // a find hit completes with ok status
   a_find_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !scan_rm_ff && scan_hit)
      |=> (state_ff == ST_DONE) && (res_stat_ff == bvt_pkg::STAT_OK))
      else $error("find hit not completed");

endmodule

[dv/tb_bounded_vector_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_vector_table
// Self-checking bench for the bounded list. A directed table covers the empty,
// full and bad-position cases and the word extremes. Random traffic follows in
// three idling phases, biased so that fill and drain runs push the list to
// both ends. A shadow copy of the list predicts every result that the table
// does not pin, and results are checked field by field in transfer order.
// ----------------------------------------------------------------------------
module tb_bounded_vector_table;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int END_CYCLES  = 40;

   // action code with no meaning, the block only reports the count
   localparam logic [bvt_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [bvt_pkg::WORD_W-1:0] data;
      logic [bvt_pkg::INDEX_W-1:0]       index;
      logic [bvt_pkg::COUNT_W-1:0]       removed;
      logic [bvt_pkg::COUNT_W-1:0]       count;
      logic                              empty;
      logic [bvt_pkg::STATUS_W-1:0]      status;
   } list_result_type;

   typedef struct {
      logic [bvt_pkg::ACTION_W-1:0]      action;
      logic [bvt_pkg::POSITION_W-1:0]    position;
      logic signed [bvt_pkg::WORD_W-1:0] value;
      int                                repeats;
      bit                                pinned;
      list_result_type                   result;
   } stim_row_type;

   logic clock;
   logic reset;

   bvt_req_if req_bus ();
   bvt_rsp_if rsp_bus ();

   bounded_vector_table #(.CAPACITY(CAPACITY)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow list and pending results
   logic signed [bvt_pkg::WORD_W-1:0] shadow_cells [$];
   int                                shadow_count;
   list_result_type                   expected_results [$];
   stim_row_type                      directed_rows [$];
   logic signed [bvt_pkg::WORD_W-1:0] value_pool [0:5];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count  = 0;
   int results_checked = 0;
   int requests_sent;
   int directed_items;
   int cycle_count     = 0;
   int status_hits [0:7] = '{default: 0};

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("FAIL bounded_vector_table");
      $finish;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at result %0d", what, got, want,
               results_checked);
      mismatch_count++;
   endtask

   // shadow list update, returns the result the block owes for this request
   function automatic list_result_type apply_request(
         input logic [bvt_pkg::ACTION_W-1:0] act,
         input logic [bvt_pkg::POSITION_W-1:0] pos,
         input logic signed [bvt_pkg::WORD_W-1:0] val);
      list_result_type res;
      int              keep;
      int              i;
      res = '0;
      res.status = bvt_pkg::STAT_OK;
      case (act)
         bvt_pkg::ACT_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               res.status = bvt_pkg::STAT_FULL;
            end else begin
               shadow_cells[shadow_count] = val;
               shadow_count++;
            end
         end
         bvt_pkg::ACT_POP: begin
            if (shadow_count == 0) begin
               res.status = bvt_pkg::STAT_EMPTY;
            end else begin
               shadow_count--;
               res.data = shadow_cells[shadow_count];
            end
         end
         bvt_pkg::ACT_INSERT: begin
            // position is checked before fullness
            if (pos > shadow_count) begin
               res.status = bvt_pkg::STAT_BADPOS;
            end else if (shadow_count >= CAPACITY) begin
               res.status = bvt_pkg::STAT_FULL;
            end else begin
               for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[pos] = val;
               shadow_count++;
            end
         end
         bvt_pkg::ACT_DELETE: begin
            if (shadow_count == 0) begin
               res.status = bvt_pkg::STAT_EMPTY;
            end else if (pos >= shadow_count) begin
               res.status = bvt_pkg::STAT_BADPOS;
            end else begin
               for (i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_count--;
            end
         end
         bvt_pkg::ACT_REMOVE: begin
            if (shadow_count == 0) begin
               res.status = bvt_pkg::STAT_EMPTY;
            end else begin
               // compact the survivors toward the front
               keep = 0;
               for (i = 0; i < shadow_count; i++) begin
                  if (shadow_cells[i] !== val) begin
                     shadow_cells[keep] = shadow_cells[i];
                     keep++;
                  end
               end
               res.removed = bvt_pkg::COUNT_W'(shadow_count - keep);
               shadow_count = keep;
               if (res.removed == 0) res.status = bvt_pkg::STAT_NOTFOUND;
            end
         end
         bvt_pkg::ACT_FIND: begin
            if (shadow_count == 0) begin
               res.status = bvt_pkg::STAT_EMPTY;
            end else begin
               // scan downward so the lowest match wins
               res.status = bvt_pkg::STAT_NOTFOUND;
               for (i = shadow_count - 1; i >= 0; i--) begin
                  if (shadow_cells[i] === val) begin
                     res.index = bvt_pkg::INDEX_W'(i);
                     res.status = bvt_pkg::STAT_OK;
                  end
               end
            end
         end
         bvt_pkg::ACT_READ: begin
            if (shadow_count == 0) begin
               res.status = bvt_pkg::STAT_EMPTY;
            end else if (pos >= shadow_count) begin
               res.status = bvt_pkg::STAT_BADPOS;
            end else begin
               res.data = shadow_cells[pos];
            end
         end
         default: ;
      endcase
      res.count = bvt_pkg::COUNT_W'(shadow_count);
      res.empty = (shadow_count == 0);
      return res;
   endfunction

   // one request transfer, with random sender gaps ahead of it
   task automatic send_request(input logic [bvt_pkg::ACTION_W-1:0] act,
                               input logic [bvt_pkg::POSITION_W-1:0] pos,
                               input logic signed [bvt_pkg::WORD_W-1:0] val,
                               input bit pinned, input list_result_type pinned_result);
      list_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.position <= pos;
      req_bus.value    <= val;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_request(act, pos, val);
      expected_results.push_back(pinned ? pinned_result : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // sender holds off until every owed result is back
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [bvt_pkg::ACTION_W-1:0] act,
                          input logic [bvt_pkg::POSITION_W-1:0] pos,
                          input logic signed [bvt_pkg::WORD_W-1:0] val, input int reps,
                          input bit pinned, input logic signed [bvt_pkg::WORD_W-1:0] data,
                          input int count, input logic [bvt_pkg::STATUS_W-1:0] status);
      stim_row_type row;
      row.action   = act;
      row.position = pos;
      row.value    = val;
      row.repeats  = reps;
      row.pinned   = pinned;
      row.result   = '0;
      row.result.data   = data;
      row.result.count  = bvt_pkg::COUNT_W'(count);
      row.result.empty  = (count == 0);
      row.result.status = status;
      directed_rows.push_back(row);
   endtask

   // word for a request, often one already held so finds and removes hit
   function automatic logic signed [bvt_pkg::WORD_W-1:0] pick_value(input bit lookup);
      if (lookup && shadow_count > 0 && $urandom_range(0, 1) == 1)
         return shadow_cells[$urandom_range(0, shadow_count - 1)];
      if ($urandom_range(0, 99) < 55) return value_pool[3'($urandom_range(0, 5))];
      return $urandom();
   endfunction

   // random traffic with fill and drain runs mixed into plain requests
   task automatic run_random_phase(input int items, input int send_pct,
                                   input int recv_pct);
      int                                n;
      int                                r;
      int                                burst_left;
      bit                                filling;
      logic [bvt_pkg::ACTION_W-1:0]      act;
      logic [bvt_pkg::POSITION_W-1:0]    pos;
      logic signed [bvt_pkg::WORD_W-1:0] val;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      burst_left = 0;
      filling = 1'b0;
      for (n = 0; n < items; n++) begin
         if (n == items / 3) hold_until_drained();
         if (burst_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               filling = 1'b1;
               burst_left = CAPACITY - shadow_count + $urandom_range(1, 3);
            end else if (r < 9) begin
               filling = 1'b0;
               burst_left = shadow_count + $urandom_range(1, 2);
            end
         end
         r = $urandom_range(0, 99);
         if (burst_left > 0) begin
            burst_left--;
            if (filling) begin
               act = (r < 70) ? bvt_pkg::ACT_APPEND : bvt_pkg::ACT_INSERT;
               pos = bvt_pkg::POSITION_W'($urandom_range(0, shadow_count));
            end else begin
               act = (r < 60) ? bvt_pkg::ACT_POP : bvt_pkg::ACT_DELETE;
               pos = (shadow_count > 0) ?
                     bvt_pkg::POSITION_W'($urandom_range(0, shadow_count - 1)) : '0;
            end
         end else begin
            if (r < 18)      act = bvt_pkg::ACT_APPEND;
            else if (r < 28) act = bvt_pkg::ACT_INSERT;
            else if (r < 42) act = bvt_pkg::ACT_POP;
            else if (r < 54) act = bvt_pkg::ACT_DELETE;
            else if (r < 66) act = bvt_pkg::ACT_REMOVE;
            else if (r < 80) act = bvt_pkg::ACT_FIND;
            else if (r < 97) act = bvt_pkg::ACT_READ;
            else             act = ACT_UNUSED;
            // mostly within the list or at its end, sometimes anywhere in the field
            if ($urandom_range(0, 99) < 85)
               pos = bvt_pkg::POSITION_W'($urandom_range(0, shadow_count));
            else
               pos = bvt_pkg::POSITION_W'($urandom_range(0, 31));
         end
         val = pick_value(act == bvt_pkg::ACT_REMOVE || act == bvt_pkg::ACT_FIND);
         send_request(act, pos, val, 1'b0, '0);
      end
      hold_until_drained();
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_bus.status), 32'd0);
         end else begin
            want = expected_results.pop_front();
            status_hits[want.status]++;
            if (rsp_bus.data_out !== want.data)
               report_mismatch("data_out", rsp_bus.data_out, want.data);
            if (rsp_bus.found_index !== want.index)
               report_mismatch("found_index", 32'(rsp_bus.found_index), 32'(want.index));
            if (rsp_bus.removed_count !== want.removed)
               report_mismatch("removed_count", 32'(rsp_bus.removed_count),
                               32'(want.removed));
            if (rsp_bus.element_count !== want.count)
               report_mismatch("element_count", 32'(rsp_bus.element_count),
                               32'(want.count));
            if (rsp_bus.empty_flag !== want.empty)
               report_mismatch("empty_flag", 32'(rsp_bus.empty_flag), 32'(want.empty));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
            results_checked++;
         end
      end
   end

   // main sequence
   initial begin
      reset = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.action   = bvt_pkg::ACT_APPEND;
      req_bus.position = '0;
      req_bus.value    = '0;
      shadow_count     = 0;
      requests_sent    = 0;
      directed_items   = 0;
      repeat (CAPACITY) shadow_cells.push_back('0);
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      value_pool[4] = 32'sd1;
      value_pool[5] = $urandom();
      send_idle_pct = 29;
      recv_idle_pct = 61;

      // empty list, bad positions, extremes, full list, drain
      add_row(bvt_pkg::ACT_POP,    0,  0,            1,  1, 0, 0, bvt_pkg::STAT_EMPTY);
      add_row(bvt_pkg::ACT_READ,   0,  0,            1,  1, 0, 0, bvt_pkg::STAT_EMPTY);
      add_row(bvt_pkg::ACT_DELETE, 0,  0,            1,  1, 0, 0, bvt_pkg::STAT_EMPTY);
      add_row(bvt_pkg::ACT_REMOVE, 0,  5,            1,  1, 0, 0, bvt_pkg::STAT_EMPTY);
      add_row(bvt_pkg::ACT_FIND,   0,  5,            1,  1, 0, 0, bvt_pkg::STAT_EMPTY);
      add_row(bvt_pkg::ACT_INSERT, 1,  9,            1,  1, 0, 0, bvt_pkg::STAT_BADPOS);
      add_row(bvt_pkg::ACT_INSERT, 0,  32'sh8000_0000, 1, 1, 0, 1, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_APPEND, 0,  32'sh7fff_ffff, 1, 1, 0, 2, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_APPEND, 0,  -32'sd1,      1,  1, 0, 3, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_READ,   31, 0,            1,  1, 0, 3, bvt_pkg::STAT_BADPOS);
      add_row(bvt_pkg::ACT_DELETE, 3,  0,            1,  1, 0, 3, bvt_pkg::STAT_BADPOS);
      add_row(bvt_pkg::ACT_INSERT, 4,  0,            1,  1, 0, 3, bvt_pkg::STAT_BADPOS);
      add_row(bvt_pkg::ACT_READ,   0,  0,      1, 1, 32'sh8000_0000, 3, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_FIND,   0,  32'sh7fff_ffff, 1, 0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_FIND,   0,  1234,         1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_REMOVE, 0,  1234,         1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_APPEND, 0,  -32'sd1,      13, 0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_APPEND, 0,  0,            1,  1, 0, 16, bvt_pkg::STAT_FULL);
      add_row(bvt_pkg::ACT_INSERT, 16, 0,            1,  1, 0, 16, bvt_pkg::STAT_FULL);
      add_row(bvt_pkg::ACT_INSERT, 17, 0,            1,  1, 0, 16, bvt_pkg::STAT_BADPOS);
      add_row(bvt_pkg::ACT_READ,   15, 0,            1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_POP,    0,  0,            1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_REMOVE, 0,  -32'sd1,      1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_DELETE, 0,  0,            1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(bvt_pkg::ACT_POP,    0,  0,            1,  0, 0, 0, bvt_pkg::STAT_OK);
      add_row(ACT_UNUSED,          31, -32'sd1,      1,  1, 0, 0, bvt_pkg::STAT_OK);

      // reset
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[k]) begin
         repeat (directed_rows[k].repeats) begin
            send_request(directed_rows[k].action, directed_rows[k].position,
                         directed_rows[k].value, directed_rows[k].pinned,
                         directed_rows[k].result);
            directed_items++;
         end
      end
      hold_until_drained();

      // random traffic, receiver-heavy gaps, then sender-heavy, then none
      run_random_phase(450, 29, 61);
      run_random_phase(450, 61, 29);
      run_random_phase(450, 0, 0);

      repeat (END_CYCLES) @(negedge clock);

      $display("ran %0d requests (%0d from the directed table), checked %0d results",
               requests_sent, directed_items, results_checked);
      $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
               status_hits[bvt_pkg::STAT_OK], status_hits[bvt_pkg::STAT_FULL],
               status_hits[bvt_pkg::STAT_EMPTY], status_hits[bvt_pkg::STAT_BADPOS],
               status_hits[bvt_pkg::STAT_NOTFOUND]);
      if (mismatch_count == 0) begin
         $display("PASS bounded_vector_table");
      end else begin
         $display("FAIL bounded_vector_table");
      end
      $finish;
   end

endmodule
